>>> src/ntc_pkg.sv
// Package for the NTC thermistor temperature block.
// Holds shared widths, constants, register indexes and the stage record type.
// No dependencies.
package ntc_pkg;

	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned CFG_W     = 20;
	localparam int unsigned M_W       = 31;
	localparam int unsigned POS_W     = 6;

	localparam logic [29:0] LN2_Q30      = 30'd744261118;
	localparam logic [16:0] CENTI_ABS    = 17'd27315;
	localparam logic [20:0] NK_MAX       = 21'd1000000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_VREF  = 3'd0,
		REG_RS    = 3'd1,
		REG_R0    = 3'd2,
		REG_T0    = 3'd3,
		REG_BETA  = 3'd4,
		REG_VMIN  = 3'd5,
		REG_VMAX  = 3'd6,
		REG_NONE  = 3'd7
	} reg_idx_t;

	// Special outcomes decided before the arithmetic settles.
	typedef struct packed {
		logic fault;
		logic abs_zero;
	} item_flags_t;

	// Leading-one position of a 37-bit value.
	function automatic logic [POS_W-1:0] lead_pos(input logic [36:0] x);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < 37; i++) begin
			if (x[i]) p = POS_W'(i);
		end
		return p;
	endfunction

endpackage

>>> src/ntc_thermistor_temperature.sv
// Top level of the NTC thermistor temperature block (beta equation, fixed point).
// Depends on ntc_pkg, ntc_log2 and ntc_divider.
//
// Usage: readings in millivolts arrive on the s_axis channel; each transfer
// yields exactly one m_axis transfer with the temperature in hundredths of a
// degree Celsius and a fault bit. Configuration registers are written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Pipeline stages from input transfer to output register: one window and
// product stage, one normalize stage plus one squaring stage per log bit in
// the log unit, a subtract stage, an ln2 product stage, a denominator stage,
// a divider of LN_FRAC_BITS + 31 stages, one result stage.
// Throughput: one item per cycle while the receiver does not stall; the
// whole pipeline advances together.
// When the receiver stalls, the pipeline freezes with the output register
// held; s_axis_tready falls while m_axis_tvalid is high and m_axis_tready low.
// Reset clears all valid bits and restores the register defaults.
module ntc_thermistor_temperature #(
	parameter int LN_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] reading_mv
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] temp_centi_c, [16] sensor_failed, zero fill
	input  logic        cfg_we,
	input  logic [ntc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0]     cfg_data
);
	localparam int F    = LN_FRAC_BITS;
	localparam int LW   = ntc_pkg::POS_W + F;
	localparam int SW   = 2;
	localparam int NW   = 31 + F;
	localparam int DW   = 26 + F;

	logic [15:0] vref_q, vmin_q, vmax_q;
	logic [19:0] rs_q, r0_q;
	logic [9:0]  t0_q;
	logic [13:0] beta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q <= 16'd3300;
			rs_q   <= 20'd10000;
			r0_q   <= 20'd10000;
			t0_q   <= 10'd298;
			beta_q <= 14'd3950;
			vmin_q <= 16'd0;
			vmax_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (ntc_pkg::reg_idx_t'(cfg_index))
				ntc_pkg::REG_VREF: vref_q <= cfg_data[15:0];
				ntc_pkg::REG_RS:   rs_q   <= cfg_data;
				ntc_pkg::REG_R0:   r0_q   <= cfg_data;
				ntc_pkg::REG_T0:   t0_q   <= cfg_data[9:0];
				ntc_pkg::REG_BETA: beta_q <= cfg_data[13:0];
				ntc_pkg::REG_VMIN: vmin_q <= cfg_data[15:0];
				ntc_pkg::REG_VMAX: vmax_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: window check, products for numerator and denominator.
	logic                     v_s1;
	ntc_pkg::item_flags_t     fl_s1;
	logic [36:0]              num_s1, den_s1;
	logic [15:0]              rd;
	assign rd = s_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s1.fault    <= (rd == 16'd0) || (rd < vmin_q) || (rd > vmax_q);
			fl_s1.abs_zero <= (rd >= vref_q) || (rs_q == '0) || (r0_q == '0)
				|| (t0_q == '0) || (beta_q == '0);
			num_s1 <= 37'(rs_q) * 37'(vref_q - rd);
			den_s1 <= 37'(rd) * 37'(r0_q);
		end
	end

	// Log stages for both operands in parallel.
	logic          lv_a, lv_b;
	logic [LW-1:0] la, lb;
	logic [SW-1:0] sd_a, sd_b;

	ntc_log2 #(.FRAC(F), .SIDE_W(SW)) u_log_num (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.x(num_s1 == '0 ? 37'd1 : num_s1), .side_in(fl_s1),
		.out_valid(lv_a), .y(la), .side_out(sd_a)
	);
	ntc_log2 #(.FRAC(F), .SIDE_W(SW)) u_log_den (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.x(den_s1 == '0 ? 37'd1 : den_s1), .side_in(fl_s1),
		.out_valid(lv_b), .y(lb), .side_out(sd_b)
	);

	// Stage 2: difference and magnitude.
	logic              v_s2;
	logic [SW-1:0]     fl_s2;
	logic              neg_s2;
	logic [LW-1:0]     mag_s2;
	logic signed [LW:0] dfl;
	assign dfl = $signed({1'b0, la}) - $signed({1'b0, lb});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= lv_a;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s2  <= sd_a;
			neg_s2 <= dfl[LW];
			mag_s2 <= dfl[LW] ? LW'(-dfl) : dfl[LW-1:0];
		end
	end

	// Stage 3: multiply by ln2 and round.
	logic              v_s3;
	logic [SW-1:0]     fl_s3;
	logic              neg_s3;
	logic [LW-1:0]     lm_s3;
	logic [LW+30:0]    lp;
	assign lp = (LW+31)'(mag_s2) * (LW+31)'(ntc_pkg::LN2_Q30) + (LW+31)'(31'h2000_0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s3  <= fl_s2;
			neg_s3 <= neg_s2;
			lm_s3  <= lp[LW+29:30];
		end
	end

	// Stage 4: beta equation denominator and scaled numerator.
	logic              v_s4;
	logic [SW-1:0]     fl_s4;
	logic              inf_s4;
	logic [NW-1:0]     nn_s4;
	logic [DW-1:0]     dd_s4;
	logic signed [DW+1:0] tl, ddv;
	assign tl  = $signed({2'b00, (DW)'(t0_q) * (DW)'(lm_s3)});
	assign ddv = $signed({2'b00, (DW)'(beta_q) << F}) + (neg_s3 ? -tl : tl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s4  <= fl_s3;
			inf_s4 <= (ddv <= 0);
			dd_s4  <= (ddv <= 0) ? (DW)'(1) : ddv[DW-1:0];
			nn_s4  <= ((NW)'(t0_q) * (NW)'(beta_q) * (NW)'(100)) << F;
		end
	end

	// Divider with round-half-up numerator.
	logic          dv;
	logic [NW-1:0] quo;
	logic [SW:0]   dsd;
	ntc_divider #(.NUM_W(NW), .DEN_W(DW), .SIDE_W(SW+1)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num(nn_s4 + NW'(dd_s4 >> 1)), .den(dd_s4),
		.side_in({inf_s4, fl_s4}), .out_valid(dv), .quo(quo), .side_out(dsd)
	);

	// Output stage.
	ntc_pkg::item_flags_t ofl;
	logic signed [22:0]   tc;
	logic [15:0]          tres;
	assign ofl = dsd[SW-1:0];
	assign tc  = $signed({2'b00, (quo > NW'(ntc_pkg::NK_MAX)) ? ntc_pkg::NK_MAX
		: quo[20:0]}) - $signed({6'd0, ntc_pkg::CENTI_ABS});

	always_comb begin
		if (ofl.fault) tres = 16'd0;
		else if (ofl.abs_zero) tres = 16'(-17'sd27315);
		else if (dsd[SW]) tres = 16'h7FFF;
		else if (tc > 23'sd32767) tres = 16'h7FFF;
		else tres = tc[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= dv;
	end
	always_ff @(posedge clk) begin
		if (en) m_axis_tdata <= {7'd0, ofl.fault, tres};
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready mismatch");
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("fault with nonzero temperature");
endmodule

>>> src/ntc_log2.sv
// Pipelined fixed-point log2: one normalization stage, then one squaring stage per bit.
// Depends on ntc_pkg. The side payload rides along with each item.
module ntc_log2 #(
	parameter int FRAC = 16,
	parameter int SIDE_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [36:0]                   x,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          out_valid,
	output logic [ntc_pkg::POS_W+FRAC-1:0] y,
	output logic [SIDE_W-1:0]             side_out
);
	logic [ntc_pkg::M_W-1:0] m_s   [FRAC+1];
	logic [FRAC-1:0]         f_s   [FRAC+1];
	logic [ntc_pkg::POS_W-1:0] p_s [FRAC+1];
	logic [SIDE_W-1:0]       sd_s  [FRAC+1];
	logic                    v_s   [FRAC+1];
	logic [ntc_pkg::POS_W-1:0] p0;
	logic [67:0]             xs;

	always_comb begin
		p0 = ntc_pkg::lead_pos(x);
		xs = {x, 31'd0} >> p0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= xs[31:1];
			f_s[0]  <= '0;
			p_s[0]  <= p0;
			sd_s[0] <= side_in;
		end
	end

	for (genvar g = 0; g < FRAC; g++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] mt;
		assign sq = 62'(m_s[g]) * 62'(m_s[g]);
		assign mt = sq[61:30];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g+1]  <= mt[31] ? mt[31:1] : mt[30:0];
				f_s[g+1]  <= {f_s[g][FRAC-2:0], mt[31]};
				p_s[g+1]  <= p_s[g];
				sd_s[g+1] <= sd_s[g];
			end
		end
	end

	assign out_valid = v_s[FRAC];
	assign y         = {p_s[FRAC], f_s[FRAC]};
	assign side_out  = sd_s[FRAC];
endmodule

>>> src/ntc_divider.sv
// Pipelined restoring divider with rounding numerator already applied: one quotient bit a stage.
// Depends on nothing else; the side payload rides along with each item.
module ntc_divider #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 40,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);
	logic [DEN_W:0]      r_s  [NUM_W+1];
	logic [NUM_W-1:0]    q_s  [NUM_W+1];
	logic [DEN_W-1:0]    d_s  [NUM_W+1];
	logic [SIDE_W-1:0]   sd_s [NUM_W+1];
	logic                v_s  [NUM_W+1];

	assign r_s[0]  = '0;
	assign q_s[0]  = num;
	assign d_s[0]  = den;
	assign sd_s[0] = side_in;
	assign v_s[0]  = in_valid;

	for (genvar g = 0; g < NUM_W; g++) begin : g_st
		logic [DEN_W+1:0] sh;
		logic [DEN_W+1:0] df;
		assign sh = {r_s[g], q_s[g][NUM_W-1]};
		assign df = sh - {2'b00, d_s[g]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[g+1]  <= df[DEN_W+1] ? sh[DEN_W:0] : df[DEN_W:0];
				q_s[g+1]  <= {q_s[g][NUM_W-2:0], ~df[DEN_W+1]};
				d_s[g+1]  <= d_s[g];
				sd_s[g+1] <= sd_s[g];
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign quo       = q_s[NUM_W];
	assign side_out  = sd_s[NUM_W];
endmodule
